[src/centered_moving_average_macros.svh]
// ----------------------------------------------------------------------------
// Centered moving average: assertion macros
// Shared concurrent assertion forms for the block's modules.
// ----------------------------------------------------------------------------
`ifndef CENTERED_MOVING_AVERAGE_MACROS_SVH
`define CENTERED_MOVING_AVERAGE_MACROS_SVH

// same-cycle implication, disabled during reset
`define CMA_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("centered_moving_average: assertion failed");

// next-cycle implication, disabled during reset
`define CMA_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("centered_moving_average: assertion failed");

`endif

[src/cma_pkg.sv]
// ----------------------------------------------------------------------------
// Centered moving average: package
// Shared widths, register map and controller/datapath bundles.
// ----------------------------------------------------------------------------
package cma_pkg;

  localparam int unsigned SAMPLE_W     = 8;
  localparam int unsigned HALF_CFG_W   = 6;
  localparam int unsigned HALF_RESET   = 5;
  localparam int unsigned APB_DATA_W   = 32;
  localparam int unsigned APB_ADDR_W   = 3;

  // register index (paddr[2])
  localparam logic REG_HALF_WIDTH = 1'b0;

  typedef struct packed {
    logic accept;
    logic add;
    logic flush_init;
    logic drop;
    logic div_start;
    logic emit;
    logic k_dec;
    logic clear;
    logic flushing;
  } cma_cmd_t;

  typedef struct packed {
    logic sr_gt_half;
    logic last;
    logic k_zero;
    logic need_drop;
    logic div_done;
    logic out_free;
  } cma_sts_t;

endpackage

[src/cma_stream_if.sv]
// ----------------------------------------------------------------------------
// Centered moving average: stream interfaces
// Valid/ready channels for input samples and output means.
// ----------------------------------------------------------------------------
interface cma_in_if;
  logic                          valid;
  logic                          ready;
  logic [cma_pkg::SAMPLE_W-1:0]  sample;
  logic                          last_sample;

  modport source (output valid, output sample, output last_sample, input ready);
  modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

interface cma_out_if;
  logic                          valid;
  logic                          ready;
  logic [cma_pkg::SAMPLE_W-1:0]  mean;
  logic                          end_of_record;

  modport source (output valid, output mean, output end_of_record, input ready);
  modport sink   (input valid, input mean, input end_of_record, output ready);
endinterface

[src/cma_div.sv]
// ----------------------------------------------------------------------------
// Centered moving average: divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cma_div #(
  parameter int unsigned NUM_W = 15,
  parameter int unsigned DEN_W = 7
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o
);

  localparam int unsigned STEP_W = $clog2(NUM_W + 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [DEN_W-1:0]  rem_q, rem_d;
  logic [DEN_W-1:0]  den_q, den_d;
  logic [NUM_W-1:0]  quo_q, quo_d;
  logic [DEN_W:0]    trial;
  logic              ge;

  assign trial = {rem_q, quo_q[NUM_W-1]};
  assign ge    = trial >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = STEP_W'(NUM_W);
      rem_d  = '0;
      den_d  = den_i;
      quo_d  = num_i;
    end else if (busy_q) begin
      rem_d  = ge ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
      quo_d  = {quo_q[NUM_W-2:0], ge};
      step_d = step_q - 1'b1;
      if (step_q == STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

[src/cma_dp.sv]
// ----------------------------------------------------------------------------
// Centered moving average: datapath
// Sample store, running window sum, record counters and output register.
// ----------------------------------------------------------------------------
`include "centered_moving_average_macros.svh"

module cma_dp #(
  parameter int unsigned MAX_HALF = 63,
  parameter int unsigned HALF_W   = $clog2(MAX_HALF + 1),
  parameter int unsigned CNT_W    = $clog2(2 * MAX_HALF + 2),
  parameter int unsigned SUM_W    = cma_pkg::SAMPLE_W + CNT_W
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cma_pkg::cma_cmd_t             cmd_i,
  output cma_pkg::cma_sts_t             sts_o,
  input  logic [cma_pkg::HALF_CFG_W-1:0] half_cfg_i,
  input  logic [cma_pkg::SAMPLE_W-1:0]  sample_i,
  input  logic                          last_sample_i,
  input  logic                          div_done_i,
  input  logic [SUM_W-1:0]              quot_i,
  output logic [SUM_W-1:0]              sum_o,
  output logic [CNT_W-1:0]              count_o,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [cma_pkg::SAMPLE_W-1:0]  mean_o,
  output logic                          end_o
);

  localparam int unsigned DEPTH    = 2 * MAX_HALF + 1;
  localparam int unsigned ADDR_W   = $clog2(DEPTH);
  localparam int unsigned HALF_RST =
    (cma_pkg::HALF_RESET > MAX_HALF) ? MAX_HALF : cma_pkg::HALF_RESET;

  logic [cma_pkg::SAMPLE_W-1:0] mem_q [DEPTH];
  logic [cma_pkg::SAMPLE_W-1:0] rdata_q;
  logic [cma_pkg::SAMPLE_W-1:0] sample_q;
  logic                         last_q;
  logic [HALF_W-1:0]            active_q;
  logic [HALF_W-1:0]            k_q;
  logic [SUM_W-1:0]             sum_q;
  logic [CNT_W-1:0]             count_q;
  logic [CNT_W-1:0]             sr_q;
  logic [ADDR_W-1:0]            wp_q;
  logic                         out_valid_q;
  logic [cma_pkg::SAMPLE_W-1:0] mean_q;
  logic                         end_q;

  logic [HALF_W-1:0]            half_eff;
  logic [HALF_W-1:0]            k_init;
  logic [CNT_W-1:0]             reach;
  logic [CNT_W-1:0]             need;
  logic [CNT_W:0]               oldest_w;
  logic [ADDR_W-1:0]            oldest;
  logic                         drop_add;
  logic                         end_d;
  logic [SUM_W-1:0]             sub_val;

  assign half_eff = (half_cfg_i > cma_pkg::HALF_CFG_W'(MAX_HALF))
                    ? HALF_W'(MAX_HALF) : half_cfg_i[HALF_W-1:0];
  assign k_init   = (sr_q < CNT_W'(active_q)) ? sr_q[HALF_W-1:0] : active_q;
  assign reach    = CNT_W'(active_q) + CNT_W'(k_q);
  assign need     = (sr_q >= reach) ? reach : sr_q;
  assign drop_add = count_q > CNT_W'({active_q, 1'b0});
  assign sub_val  = drop_add ? SUM_W'(rdata_q) : '0;

  assign oldest_w = ((CNT_W + 1)'(wp_q) >= (CNT_W + 1)'(count_q))
                    ? (CNT_W + 1)'(wp_q) - (CNT_W + 1)'(count_q)
                    : (CNT_W + 1)'(wp_q) + (CNT_W + 1)'(DEPTH) - (CNT_W + 1)'(count_q);
  assign oldest   = oldest_w[ADDR_W-1:0];

  assign end_d = cmd_i.flushing ? (k_q == HALF_W'(1)) : (last_q && (active_q == '0));

  // sample store
  always_ff @(posedge clk_i) begin
    if (cmd_i.add) begin
      mem_q[wp_q] <= sample_q;
    end
    rdata_q <= mem_q[oldest];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      sample_q <= sample_i;
    end
    if (cmd_i.emit) begin
      mean_q <= quot_i[cma_pkg::SAMPLE_W-1:0];
      end_q  <= end_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q      <= 1'b0;
      active_q    <= HALF_W'(HALF_RST);
      k_q         <= '0;
      sum_q       <= '0;
      count_q     <= '0;
      sr_q        <= '0;
      wp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        last_q <= last_sample_i;
        if (sr_q == '0) begin
          active_q <= half_eff;
        end
      end
      if (cmd_i.add) begin
        sum_q   <= sum_q - sub_val + SUM_W'(sample_q);
        count_q <= drop_add ? count_q : count_q + 1'b1;
        wp_q    <= (wp_q == ADDR_W'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
        sr_q    <= (sr_q == CNT_W'(DEPTH)) ? sr_q : sr_q + 1'b1;
      end
      if (cmd_i.drop) begin
        sum_q   <= sum_q - SUM_W'(rdata_q);
        count_q <= count_q - 1'b1;
      end
      if (cmd_i.flush_init) begin
        k_q <= k_init;
      end else if (cmd_i.k_dec) begin
        k_q <= k_q - 1'b1;
      end
      if (cmd_i.clear) begin
        sum_q   <= '0;
        count_q <= '0;
        sr_q    <= '0;
        wp_q    <= '0;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.sr_gt_half = sr_q > CNT_W'(active_q);
  assign sts_o.last       = last_q;
  assign sts_o.k_zero     = (k_q == '0);
  assign sts_o.need_drop  = count_q > need;
  assign sts_o.div_done   = div_done_i;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign sum_o       = sum_q;
  assign count_o     = count_q;
  assign out_valid_o = out_valid_q;
  assign mean_o      = mean_q;
  assign end_o       = end_q;

  `CMA_ASSERT_IMPL(a_count_bound, clk_i, rst_ni, 1'b1,
                   count_q <= CNT_W'({active_q, 1'b0}) + CNT_W'(1))
  `CMA_ASSERT_IMPL(a_mean_range, clk_i, rst_ni, div_done_i,
                   quot_i[SUM_W-1:cma_pkg::SAMPLE_W] == '0)
  `CMA_ASSERT_IMPL(a_drop_keeps_one, clk_i, rst_ni, cmd_i.drop, count_q > CNT_W'(1))
  `CMA_ASSERT_NEXT(a_clear_empties, clk_i, rst_ni, cmd_i.clear,
                   (count_q == '0) && (sr_q == '0) && (sum_q == '0))

endmodule

[src/cma_ctrl.sv]
// ----------------------------------------------------------------------------
// Centered moving average: controller
// Sequences sample intake, window trimming, division and result delivery.
// ----------------------------------------------------------------------------
module cma_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cma_pkg::cma_sts_t sts_i,
  output cma_pkg::cma_cmd_t cmd_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ADD   = 3'd1;
  localparam logic [2:0] ST_CHECK = 3'd2;
  localparam logic [2:0] ST_FLUSH = 3'd3;
  localparam logic [2:0] ST_RD    = 3'd4;
  localparam logic [2:0] ST_DROP  = 3'd5;
  localparam logic [2:0] ST_DIV   = 3'd6;
  localparam logic [2:0] ST_EMIT  = 3'd7;

  logic [2:0] state_q, state_d;
  logic       flushing_q, flushing_d;

  always_comb begin
    state_d      = state_q;
    flushing_d   = flushing_q;
    cmd_o        = '0;
    cmd_o.flushing = flushing_q;
    in_ready_o   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_ADD;
        end
      end
      ST_ADD: begin
        cmd_o.add = 1'b1;
        state_d   = ST_CHECK;
      end
      ST_CHECK: begin
        priority if (sts_i.sr_gt_half) begin
          cmd_o.div_start = 1'b1;
          flushing_d      = 1'b0;
          state_d         = ST_DIV;
        end else if (sts_i.last) begin
          cmd_o.flush_init = 1'b1;
          flushing_d       = 1'b1;
          state_d          = ST_FLUSH;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        priority if (sts_i.k_zero) begin
          cmd_o.clear = 1'b1;
          flushing_d  = 1'b0;
          state_d     = ST_IDLE;
        end else if (sts_i.need_drop) begin
          state_d = ST_RD;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_DIV;
        end
      end
      ST_RD: begin
        state_d = ST_DROP;
      end
      ST_DROP: begin
        cmd_o.drop = 1'b1;
        state_d    = ST_FLUSH;
      end
      ST_DIV: begin
        if (sts_i.div_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          priority if (flushing_q) begin
            cmd_o.k_dec = 1'b1;
            state_d     = ST_FLUSH;
          end else if (sts_i.last) begin
            cmd_o.flush_init = 1'b1;
            flushing_d       = 1'b1;
            state_d          = ST_FLUSH;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      flushing_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      flushing_q <= flushing_d;
    end
  end

endmodule

[src/centered_moving_average.sv]
// ----------------------------------------------------------------------------
// Centered moving average
// Mean of samples i-N..i+N over a record, window shrunk at the record edges.
// ----------------------------------------------------------------------------
// Samples enter on in_if (valid/ready); last_sample closes a record. Means
// leave on out_if; end_of_record marks the record's final position.
// half_width (APB, address 0, reset 5) is taken up at the next record start.
// A sample with position below N gives no mean; later ones give the mean of
// position i-N. The final sample also flushes up to N pending means.
// Steps: a sample is accepted, written to the store and added to the window
// sum, and checked; a mean then comes from the bit-serial divider (one
// quotient bit per cycle over the 15-bit window sum). A flushed mean is
// preceded by a read and a drop for each sample that leaves the window.
// One sample is worked on at a time; the next is taken once the mean is in
// the output register (after its flush for a final sample) or if none is due.
// Reset clears the record; the sample store holds no state worth clearing.
// A stalled receiver holds the result in the output register; the block
// still accepts the next sample and waits only when a second mean is ready.
// ----------------------------------------------------------------------------
module centered_moving_average #(
  parameter int unsigned MAX_HALF = 63
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  cma_in_if.sink                             in_if,
  cma_out_if.source                          out_if,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [cma_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [cma_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [cma_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready
);

  localparam int unsigned HALF_W = $clog2(MAX_HALF + 1);
  localparam int unsigned CNT_W  = $clog2(2 * MAX_HALF + 2);
  localparam int unsigned SUM_W  = cma_pkg::SAMPLE_W + CNT_W;

  logic [cma_pkg::HALF_CFG_W-1:0] half_q;
  cma_pkg::cma_cmd_t              cmd;
  cma_pkg::cma_sts_t              sts;
  logic                           div_done;
  logic [SUM_W-1:0]               quot;
  logic [SUM_W-1:0]               sum;
  logic [CNT_W-1:0]               count;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q <= cma_pkg::HALF_CFG_W'(cma_pkg::HALF_RESET);
    end else if (psel && penable && pwrite && (paddr[2] == cma_pkg::REG_HALF_WIDTH)) begin
      half_q <= pwdata[cma_pkg::HALF_CFG_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == cma_pkg::REG_HALF_WIDTH)
                  ? cma_pkg::APB_DATA_W'(half_q) : '0;

  cma_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cma_dp #(
    .MAX_HALF (MAX_HALF),
    .HALF_W   (HALF_W),
    .CNT_W    (CNT_W),
    .SUM_W    (SUM_W)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .half_cfg_i    (half_q),
    .sample_i      (in_if.sample),
    .last_sample_i (in_if.last_sample),
    .div_done_i    (div_done),
    .quot_i        (quot),
    .sum_o         (sum),
    .count_o       (count),
    .out_ready_i   (out_if.ready),
    .out_valid_o   (out_if.valid),
    .mean_o        (out_if.mean),
    .end_o         (out_if.end_of_record)
  );

  cma_div #(
    .NUM_W (SUM_W),
    .DEN_W (CNT_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd.div_start),
    .num_i   (sum),
    .den_i   (count),
    .done_o  (div_done),
    .quot_o  (quot)
  );

endmodule
